// ===== hdl/hbc_pkg.sv =====
// hbc_pkg: shared types and constants of the byte histogram coverage level block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package hbc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_COVERAGE_PERCENT = 3'd0;
  localparam logic [2:0] REG_MIN_BYTES        = 3'd1;
  localparam logic [2:0] REG_DEFAULT_LEVEL    = 3'd2;
  localparam logic [2:0] REG_LEVEL_CEILING    = 3'd3;
  localparam logic [2:0] REG_LEVEL_FLOOR      = 3'd4;

  localparam int unsigned NUM_BINS = 256;
  localparam logic [7:0] MAX_BINS_USED = 8'd255;
  localparam logic [6:0] PCT_SCALE = 7'd100;
  // floor(x / 5) for x < 1024 as (x * 205) >> 10
  localparam logic [7:0] DIV5_RECIP = 8'd205;

  typedef struct packed {
    logic [6:0]  coverage_percent;
    logic [15:0] min_bytes;
    logic [7:0]  default_level;
    logic [7:0]  level_ceiling;
    logic [7:0]  level_floor;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    coverage_percent: 7'd66,
    min_bytes:        16'd100,
    default_level:    8'd64,
    level_ceiling:    8'd66,
    level_floor:      8'd38
  };

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
  } bin_req_t;

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] bins_used;
  } res_t;

  function automatic logic [7:0] div_by_five(input logic [8:0] x);
    logic [18:0] p;
    p = 19'(x) * 19'(DIV5_RECIP);
    return p[17:10];
  endfunction

endpackage

// ===== hdl/hbc_if.sv =====
// hbc_if: handshake channels of the byte histogram coverage level block
// byte input, result output and configuration write; no dependencies
`timescale 1ns / 1ps

interface hbc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hbc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic [7:0] bins_used;
  modport source (output valid, output level, output bins_used, input ready);
  modport sink (input valid, input level, input bins_used, output ready);
endinterface

interface hbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/hbc_bin_mem.sv =====
// hbc_bin_mem: 256-entry bin count memory with per-entry valid bits
// depends on hbc_pkg; one read and one write port, registered read
`timescale 1ns / 1ps

module hbc_bin_mem
  import hbc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bin_req_t               rd,
  output logic [COUNT_WIDTH-1:0] rd_data,
  input  bin_req_t               wr,
  input  logic [COUNT_WIDTH-1:0] wr_data,
  input  logic                   clear_all
);

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]    valid;
  logic [COUNT_WIDTH-1:0] rd_raw;
  logic                   rd_hit;

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_raw <= mem[rd.addr];
      rd_hit <= valid[rd.addr];
    end
    if (wr.en) begin
      mem[wr.addr] <= wr_data;
    end
  end

  // an entry never written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clear_all) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  assign rd_data = rd_hit ? rd_raw : '0;

endmodule

// ===== hdl/hbc_walk.sv =====
// hbc_walk: end-of-set walk over the bins, largest first, and level calculation
// depends on hbc_pkg; reads bin counts through the memory read port
`timescale 1ns / 1ps

module hbc_walk
  import hbc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [COUNT_WIDTH-1:0] total,
  input  cfg_t                   cfg,
  input  logic [COUNT_WIDTH-1:0] rd_data,
  output bin_req_t               rd,
  output logic                   idle,
  output logic                   res_valid,
  input  logic                   res_ready,
  output res_t                   res
);

  localparam int PW = COUNT_WIDTH + 7;
  localparam int MW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]             state;
  logic                   below_min;
  logic [PW-1:0]          pct_total;
  logic [PW-1:0]          prod_sum;
  logic [COUNT_WIDTH-1:0] sum;
  logic [7:0]             n;
  logic [NUM_BINS-1:0]    used;
  logic [8:0]             scan_addr;
  logic                   pipe_live;
  logic                   pipe_free;
  logic [7:0]             pipe_idx;
  logic [COUNT_WIDTH-1:0] best;
  logic [7:0]             best_idx;
  logic                   best_found;
  logic [COUNT_WIDTH:0]   sum_wide;
  logic [7:0]             scaled;
  logic [7:0]             diff;
  logic                   take_best;

  assign idle = (state == ST_IDLE);
  assign res_valid = (state == ST_EMIT);
  assign rd.en = (state == ST_SCAN) && !scan_addr[8];
  assign rd.addr = scan_addr[7:0];

  assign sum_wide = {1'b0, sum} + {1'b0, best};
  assign take_best = pipe_live && pipe_free && (!best_found || rd_data > best);

  // level = max(floor, ceiling - floor(2n/5)), difference taken as signed
  always_comb begin
    scaled = div_by_five({n, 1'b0});
    diff = cfg.level_ceiling - scaled;
    if (below_min) begin
      res.level = cfg.default_level;
      res.bins_used = '0;
    end else begin
      res.bins_used = n;
      if (cfg.level_ceiling < scaled || diff < cfg.level_floor) begin
        res.level = cfg.level_floor;
      end else begin
        res.level = diff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= (MW'(total) < MW'(cfg.min_bytes)) ? ST_EMIT : ST_MUL;
          end
        end
        ST_MUL: state <= ST_CMP;
        ST_CMP: begin
          state <= (prod_sum < pct_total && n != MAX_BINS_USED) ? ST_SCAN : ST_EMIT;
        end
        ST_SCAN: begin
          if (scan_addr[8]) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: state <= (best == '0) ? ST_EMIT : ST_MUL;
        ST_EMIT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          below_min <= MW'(total) < MW'(cfg.min_bytes);
          pct_total <= PW'(total) * PW'(cfg.coverage_percent);
          sum <= '0;
          n <= '0;
          used <= '0;
        end
      end
      ST_MUL: prod_sum <= PW'(sum) * PW'(PCT_SCALE);
      ST_CMP: begin
        scan_addr <= '0;
        pipe_live <= 1'b0;
        best_found <= 1'b0;
        best <= '0;
      end
      ST_SCAN: begin
        if (!scan_addr[8]) begin
          pipe_live <= 1'b1;
          pipe_free <= !used[scan_addr[7:0]];
          pipe_idx <= scan_addr[7:0];
          scan_addr <= scan_addr + 9'd1;
        end
        if (take_best) begin
          best <= rd_data;
          best_idx <= pipe_idx;
          best_found <= 1'b1;
        end
      end
      ST_ADD: begin
        // only zero bins left: the sum stays put, so the walk runs to its limit
        if (best == '0) begin
          n <= MAX_BINS_USED;
        end else begin
          sum <= sum_wide[COUNT_WIDTH] ? '1 : sum_wide[COUNT_WIDTH-1:0];
          used[best_idx] <= 1'b1;
          n <= n + 8'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/byte_histogram_coverage_level_unit.sv =====
// byte_histogram_coverage_level_unit: top level of the byte histogram coverage level block
// depends on hbc_pkg, hbc_if, hbc_bin_mem and hbc_walk
`timescale 1ns / 1ps

// Usage:
//   bytes  - one data byte per item, last_byte marks the end of a data set.
//   result - one item per data set: level and bins_used.
//   cfg    - register writes (index 0..4), always ready; write only while idle.
// Throughput: bytes are taken one per cycle outside the end-of-set walk. Each byte does a
//   read-modify-write of its bin in the bin memory (read at accept, write in the next
//   cycle); a repeat of the same bin in the next cycle is forwarded from the write stage.
// After the last byte the block stops taking bytes and walks the bins:
//   data set below min_bytes: the walk goes straight to the result;
//   otherwise each of the k bins taken (k <= 255) costs one full scan
//   of the 256-entry memory port.
// Reset clears the configuration to its defaults, the bin valid bits and the
//   total; no clearing pass is needed. The result goes through an output
//   register: while the receiver stalls, bytes of the next data set are still
//   taken, and only the next result waits. Histogram and total clear when the
//   result moves into the output register.

module byte_histogram_coverage_level_unit
  import hbc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input logic           clk,
  input logic           rst,
  hbc_byte_if.sink      bytes,
  hbc_result_if.source  result,
  hbc_cfg_if.sink       cfg
);

  cfg_t                   cfg_regs;
  logic                   accept;
  logic                   s2_valid;
  logic                   s2_last;
  logic [7:0]             s2_addr;
  logic                   s2_fwd;
  logic [COUNT_WIDTH-1:0] wr_val;
  logic [COUNT_WIDTH-1:0] bin_base;
  logic [COUNT_WIDTH-1:0] bin_next;
  logic [COUNT_WIDTH-1:0] total;
  logic [COUNT_WIDTH-1:0] mem_rd_data;
  bin_req_t               mem_rd;
  bin_req_t               mem_wr;
  bin_req_t               walk_rd;
  logic                   walk_start;
  logic                   walk_idle;
  logic                   res_valid;
  logic                   res_ready;
  res_t                   res;
  logic                   clear_set;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= CFG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_COVERAGE_PERCENT: cfg_regs.coverage_percent <= cfg.data[6:0];
        REG_MIN_BYTES:        cfg_regs.min_bytes <= cfg.data;
        REG_DEFAULT_LEVEL:    cfg_regs.default_level <= cfg.data[7:0];
        REG_LEVEL_CEILING:    cfg_regs.level_ceiling <= cfg.data[7:0];
        REG_LEVEL_FLOOR:      cfg_regs.level_floor <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // byte path: stop taking bytes from the last byte until the walk is back to idle
  assign bytes.ready = walk_idle && !(s2_valid && s2_last);
  assign accept = bytes.valid && bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_addr <= bytes.data_byte;
      s2_last <= bytes.last_byte;
      // read of this byte races the write of the one before it
      s2_fwd <= s2_valid && (s2_addr == bytes.data_byte);
    end
    if (s2_valid) begin
      wr_val <= bin_next;
    end
  end

  // saturating bin increment in the write stage
  assign bin_base = s2_fwd ? wr_val : mem_rd_data;
  assign bin_next = (&bin_base) ? bin_base : bin_base + COUNT_WIDTH'(1);

  assign mem_wr.en = s2_valid;
  assign mem_wr.addr = s2_addr;

  // byte total, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (clear_set) begin
      total <= '0;
    end else if (accept && !(&total)) begin
      total <= total + COUNT_WIDTH'(1);
    end
  end

  // read port goes to the byte path while idle, to the walk otherwise
  always_comb begin
    if (walk_idle) begin
      mem_rd.en = accept;
      mem_rd.addr = bytes.data_byte;
    end else begin
      mem_rd = walk_rd;
    end
  end

  // the walk starts in the cycle the last byte's count is written
  assign walk_start = s2_valid && s2_last;
  assign clear_set = res_valid && res_ready;

  hbc_bin_mem #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_bin_mem (
    .clk       (clk),
    .rst       (rst),
    .rd        (mem_rd),
    .rd_data   (mem_rd_data),
    .wr        (mem_wr),
    .wr_data   (bin_next),
    .clear_all (clear_set)
  );

  hbc_walk #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .start     (walk_start),
    .total     (total),
    .cfg       (cfg_regs),
    .rd_data   (mem_rd_data),
    .rd        (walk_rd),
    .idle      (walk_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (clear_set) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear_set) begin
      result.level <= res.level;
      result.bins_used <= res.bins_used;
    end
  end

endmodule

// ===== bench/testbench.sv =====
// testbench for byte_histogram_coverage_level_unit: directed and random data sets,
// with a level tracker class that mirrors the histogram walk and checks each result
// depends on hbc_pkg, hbc_if and the rtl of the unit
`timescale 1ns / 1ps

import hbc_pkg::*;

class level_tracker;
  localparam logic [63:0] COUNT_MAX = (64'd1 << 32) - 64'd1;
  localparam int MAX_REPORTS = 10;

  cfg_t        regs;
  logic [63:0] tally [NUM_BINS];
  logic [63:0] total;
  res_t        levels_due [$];
  int          faults;
  int          results_seen;
  int          sets_done;
  int          bytes_in;
  int          reg_writes;

  function new();
    regs = CFG_RESET;
    clear_histogram();
    faults = 0;
    results_seen = 0;
    sets_done = 0;
    bytes_in = 0;
    reg_writes = 0;
  endfunction

  function void clear_histogram();
    for (int i = 0; i < NUM_BINS; i++) tally[i] = '0;
    total = '0;
  endfunction

  function logic [63:0] bump(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > COUNT_MAX) ? COUNT_MAX : s;
  endfunction

  function int outstanding();
    return levels_due.size();
  endfunction

  function void write_reg(input logic [2:0] idx, input logic [15:0] val);
    reg_writes++;
    case (idx)
      REG_COVERAGE_PERCENT: regs.coverage_percent = val[6:0];
      REG_MIN_BYTES:        regs.min_bytes = val;
      REG_DEFAULT_LEVEL:    regs.default_level = val[7:0];
      REG_LEVEL_CEILING:    regs.level_ceiling = val[7:0];
      REG_LEVEL_FLOOR:      regs.level_floor = val[7:0];
      default: ;
    endcase
  endfunction

  // largest bins first until they cover the share, then scale the bin count
  function res_t estimate_level();
    logic [63:0] order [NUM_BINS];
    logic [63:0] v;
    logic [63:0] acc;
    int          j;
    int          n;
    int          lvl;
    res_t        r;
    if (total < 64'(regs.min_bytes)) begin
      r.level = regs.default_level;
      r.bins_used = 8'd0;
      return r;
    end
    for (int i = 0; i < NUM_BINS; i++) begin
      v = tally[i];
      j = i;
      while (j > 0 && order[j - 1] < v) begin
        order[j] = order[j - 1];
        j--;
      end
      order[j] = v;
    end
    acc = '0;
    n = 0;
    while (n < int'(MAX_BINS_USED) &&
           acc * 64'd100 < 64'(regs.coverage_percent) * total) begin
      acc = bump(acc, order[n]);
      n++;
    end
    lvl = int'(regs.level_ceiling) - (n * 2) / 5;
    if (lvl < int'(regs.level_floor)) lvl = int'(regs.level_floor);
    r.level = 8'(lvl);
    r.bins_used = 8'(n);
    return r;
  endfunction

  function void take_byte(input logic [7:0] b, input logic last);
    tally[b] = bump(tally[b], 64'd1);
    total = bump(total, 64'd1);
    bytes_in++;
    if (last) begin
      levels_due = {levels_due, estimate_level()};
      clear_histogram();
      sets_done++;
    end
  endfunction

  function void match_result(input logic [7:0] lv, input logic [7:0] bu);
    res_t want;
    results_seen++;
    if (levels_due.size() == 0) begin
      faults++;
      if (faults <= MAX_REPORTS)
        $display("%0t: unexpected result level %0d bins_used %0d", $realtime, lv, bu);
      return;
    end
    want = levels_due.pop_front();
    if (want.level !== lv || want.bins_used !== bu) begin
      faults++;
      if (faults <= MAX_REPORTS)
        $display("%0t: result %0d: level exp %0d got %0d, bins_used exp %0d got %0d",
                 $realtime, results_seen, want.level, lv, want.bins_used, bu);
    end
  endfunction
endclass

module testbench;
  localparam int CHUNKS          = 9;
  localparam int ITEMS_PER_CHUNK = 55;
  localparam int SETTLE_CYCLES   = 16;   // pipeline slack before a register write
  localparam int TAIL_CYCLES     = 300;  // watch for stray results at the end
  localparam int LONG_HOLD       = 4000; // receiver stall that backs up the input

  logic clk = 1'b0;
  logic rst = 1'b1;

  hbc_byte_if   bytes_ch ();
  hbc_result_if result_ch ();
  hbc_cfg_if    cfg_ch ();

  level_tracker tracker;

  // idle shares in percent, changed per phase by the main sequence
  int src_idle_pct  = 26;
  int sink_idle_pct = 66;
  bit hold_pending  = 1'b0;
  int hold_left     = 0;

  byte_histogram_coverage_level_unit uut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop in case the unit hangs
  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // result monitor: sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      tracker.match_result(result_ch.level, result_ch.bins_used);
  end

  // one byte item; valid stays high into the next call unless a gap is drawn
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      bytes_ch.valid <= 1'b0;
      @(negedge clk);
    end
    bytes_ch.valid     <= 1'b1;
    bytes_ch.data_byte <= b;
    bytes_ch.last_byte <= last;
    do @(posedge clk); while (!bytes_ch.ready);
    tracker.take_byte(b, last);
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    @(negedge clk);
    bytes_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // writes to unused indexes first, then all five registers; junk fills unused bits
  task automatic load_regs(input cfg_t c, input bit junk, input int strays);
    logic [2:0]  idx;
    logic [15:0] val;
    for (int i = 0; i < strays + 5; i++) begin
      if (i < strays) begin
        idx = 3'(5 + i);
        val = 16'($urandom);
      end else begin
        idx = 3'(i - strays);
        case (idx)
          REG_COVERAGE_PERCENT: val = {junk ? 9'($urandom) : 9'd0, c.coverage_percent};
          REG_MIN_BYTES:        val = c.min_bytes;
          REG_DEFAULT_LEVEL:    val = {junk ? 8'($urandom) : 8'd0, c.default_level};
          REG_LEVEL_CEILING:    val = {junk ? 8'($urandom) : 8'd0, c.level_ceiling};
          REG_LEVEL_FLOOR:      val = {junk ? 8'($urandom) : 8'd0, c.level_floor};
          default:              val = 16'd0;
        endcase
      end
      @(negedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= val;
      do @(posedge clk); while (!cfg_ch.ready);
      tracker.write_reg(idx, val);
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // random settings per chunk, a few chunks pinned to the extremes
  function automatic cfg_t pick_cfg(input int chunk);
    cfg_t c;
    c.coverage_percent = 7'($urandom_range(0, 100));
    c.min_bytes = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    c.default_level = 8'($urandom);
    c.level_ceiling = 8'($urandom);
    c.level_floor = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                 : 8'($urandom_range(0, c.level_ceiling));
    case (chunk)
      0: c = '{coverage_percent: 7'd100, min_bytes: 16'd0, default_level: 8'd0,
               level_ceiling: 8'd255, level_floor: 8'd0};
      4: c = '{coverage_percent: 7'd1, min_bytes: 16'hFFFF, default_level: 8'd255,
               level_ceiling: 8'd0, level_floor: 8'd255};
      7: c.coverage_percent = 7'd0;
      default: ;
    endcase
    return c;
  endfunction

  // a complete data set: mostly small alphabets so the walk stays short,
  // some raw random bytes and some longer skewed sets
  task automatic send_random_set(output int len);
    int         kind;
    int         alph;
    logic [7:0] vals [6];
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    alph = $urandom_range(1, 6);
    for (int k = 0; k < 6; k++) vals[k] = 8'($urandom);
    if (kind < 15) len = $urandom_range(20, 60);
    else if (kind < 40) len = $urandom_range(1, 6);
    else len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      if (kind < 15)
        b = ($urandom_range(0, 4) != 0) ? vals[0] : vals[$urandom_range(0, 3)];
      else if (kind < 40)
        b = 8'($urandom);
      else
        b = vals[$urandom_range(0, alph - 1)];
      send_byte(b, i == len - 1);
    end
  endtask

  initial begin
    int sent;
    int len;
    tracker = new();
    bytes_ch.valid     = 1'b0;
    bytes_ch.data_byte = 8'd0;
    bytes_ch.last_byte = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = 3'd0;
    cfg_ch.data        = 16'd0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: a one-byte set is below the minimum size
    send_byte(8'h00, 1'b1);
    drain();

    // extreme byte values, writes to the unused indexes
    load_regs('{7'd66, 16'd0, 8'd0, 8'd255, 8'd0}, 1'b0, 3);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b1);
    drain();

    // zero coverage: no bins taken, level is the ceiling
    load_regs('{7'd0, 16'd0, 8'd0, 8'd200, 8'd17}, 1'b1, 0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
    drain();

    // percent above 100 walks the full 255 bins; ceiling below scaled gives the floor
    load_regs('{7'd127, 16'd0, 8'd0, 8'd100, 8'd10}, 1'b0, 0);
    send_byte(8'h7F, 1'b1);
    drain();

    // full coverage over eight distinct bins
    load_regs('{7'd100, 16'd0, 8'd9, 8'd255, 8'd0}, 1'b1, 0);
    for (int k = 0; k < 8; k++) send_byte(8'(1 << k), k == 7);
    drain();

    // size exactly at the minimum, then one byte short of it
    load_regs('{7'd50, 16'd3, 8'd200, 8'd30, 8'd20}, 1'b0, 0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b1);
    drain();

    // largest minimum: everything falls back to the default
    load_regs('{7'd1, 16'hFFFF, 8'd255, 8'd0, 8'd0}, 1'b0, 0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b1);
    drain();

    // random part: three idling phases of three chunks, new settings per chunk
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      if (chunk == 3) begin
        src_idle_pct  = 66;
        sink_idle_pct = 26;
      end
      if (chunk == 6) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      load_regs(pick_cfg(chunk), 1'($urandom_range(0, 1)), $urandom_range(0, 3));
      // long receiver hold-off while the sender keeps pushing items
      if (chunk == 6) hold_pending = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_CHUNK) begin
        send_random_set(len);
        sent += len;
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run covered %0d data sets, %0d bytes and %0d register writes",
             tracker.sets_done, tracker.bytes_in, tracker.reg_writes);
    $display("%0d results checked across three idling phases and one long receiver stall",
             tracker.results_seen);
    if (tracker.faults == 0 && tracker.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results still outstanding",
               tracker.faults, tracker.outstanding());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/hbc_pkg.sv
hdl/hbc_if.sv
hdl/hbc_bin_mem.sv
hdl/hbc_walk.sv
hdl/byte_histogram_coverage_level_unit.sv
bench/testbench.sv
